FILE: src/sladm_pkg.sv
// ----------------------------------------------------------------------------
// sladm_pkg: shared types and constants of the slew-limited arcade drive mixer
// Widths, reset values, register map, sequencer states and control bundles.
// ----------------------------------------------------------------------------
package sladm_pkg;

  localparam int unsigned StickW = 8;
  localparam int unsigned LevelW = 15;
  localparam int unsigned MulAW  = 25;
  localparam int unsigned MulBW  = 18;
  localparam int unsigned MulPW  = MulAW + MulBW;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;

  localparam logic [LevelW-1:0] LevelMax = 15'h7fff;

  // floor(2^24 / 127); q = (x * GoalRecip) >> 24 is exact or one low.
  localparam logic [MulBW-1:0] GoalRecip  = 18'd132104;
  localparam int unsigned      RecipShift = 24;

  localparam logic        MergeRst = 1'b1;
  localparam logic        StdRst   = 1'b1;
  localparam logic [14:0] RiseRst  = 15'd12800;
  localparam logic [15:0] FallRst  = 16'hce00;
  localparam logic [7:0]  GainRst  = 8'd179;
  localparam logic [15:0] TrimRst  = 16'd32605;

  typedef enum logic [2:0] {
    REG_MERGE   = 3'd0,
    REG_STD_MIX = 3'd1,
    REG_RISE    = 3'd2,
    REG_FALL    = 3'd3,
    REG_GAIN    = 3'd4,
    REG_TRIM    = 3'd5
  } sladm_reg_e;

  typedef enum logic [1:0] {
    MUL_SQUARE,
    MUL_RECIP,
    MUL_GAIN,
    MUL_TRIM
  } sladm_mul_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_F_SQ,
    ST_F_DIV,
    ST_F_GOAL,
    ST_F_SLEW,
    ST_T_SQ,
    ST_T_DIV,
    ST_T_GOAL,
    ST_T_SLEW,
    ST_GAIN,
    ST_MIX,
    ST_TRIM,
    ST_DONE
  } sladm_state_e;

  typedef struct packed {
    logic           idle;
    logic           mul_en;
    sladm_mul_sel_e mul_sel;
    logic           chan;     // 0: forward channel, 1: turn channel
    logic           ld_mm;
    logic           ld_goal;
    logic           ld_level;
    logic           ld_mix;
    logic           ld_out;
  } sladm_ctl_t;

  typedef struct packed {
    logic        merge_turn_stick;
    logic        standard_mix;
    logic [14:0] rise_step;
    logic [15:0] fall_step;
    logic [7:0]  turn_gain;
    logic [15:0] right_trim;
  } sladm_cfg_t;

  // Clamp a magnitude to 127 and apply the sign.
  function automatic logic [StickW-1:0] sat_drive(input logic neg, input logic [11:0] mag);
    logic [6:0] m7;
    m7 = (mag > 12'd127) ? 7'd127 : mag[6:0];
    return neg ? 8'(-{1'b0, m7}) : {1'b0, m7};
  endfunction

endpackage

FILE: src/sladm_cfg.sv
// ----------------------------------------------------------------------------
// sladm_cfg: configuration register file
// APB-style write and read access to the six mixer registers.
// ----------------------------------------------------------------------------
module sladm_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sladm_pkg::AddrW-1:0] paddr,
  input  logic [sladm_pkg::DataW-1:0] pwdata,
  output logic [sladm_pkg::DataW-1:0] prdata,
  output logic                        pready,
  output sladm_pkg::sladm_cfg_t       cfg_o
);
  import sladm_pkg::*;

  sladm_cfg_t cfg_q, cfg_d;
  logic       wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (paddr[4:2])
        REG_MERGE:   cfg_d.merge_turn_stick = pwdata[0];
        REG_STD_MIX: cfg_d.standard_mix     = pwdata[0];
        REG_RISE:    cfg_d.rise_step        = pwdata[14:0];
        REG_FALL:    cfg_d.fall_step        = pwdata[15:0];
        REG_GAIN:    cfg_d.turn_gain        = pwdata[7:0];
        REG_TRIM:    cfg_d.right_trim       = pwdata[15:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.merge_turn_stick <= MergeRst;
      cfg_q.standard_mix     <= StdRst;
      cfg_q.rise_step        <= RiseRst;
      cfg_q.fall_step        <= FallRst;
      cfg_q.turn_gain        <= GainRst;
      cfg_q.right_trim       <= TrimRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_MERGE:   prdata = {31'b0, cfg_q.merge_turn_stick};
      REG_STD_MIX: prdata = {31'b0, cfg_q.standard_mix};
      REG_RISE:    prdata = {17'b0, cfg_q.rise_step};
      REG_FALL:    prdata = {{16{cfg_q.fall_step[15]}}, cfg_q.fall_step};
      REG_GAIN:    prdata = {24'b0, cfg_q.turn_gain};
      REG_TRIM:    prdata = {16'b0, cfg_q.right_trim};
      default:     prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: src/sladm_mul.sv
// ----------------------------------------------------------------------------
// sladm_mul: shared unsigned multiplier
// One 25 x 18 bit multiply per enabled cycle into a product register.
// ----------------------------------------------------------------------------
module sladm_mul (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [sladm_pkg::MulAW-1:0] a_i,
  input  logic [sladm_pkg::MulBW-1:0] b_i,
  output logic [sladm_pkg::MulPW-1:0] p_o
);
  import sladm_pkg::*;

  logic [MulPW-1:0] p_q, p_d;

  // The product holds while the unit is not enabled.
  assign p_d = en_i ? ({{MulBW{1'b0}}, a_i} * {{MulAW{1'b0}}, b_i}) : p_q;

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

FILE: src/sladm_ctrl.sv
// ----------------------------------------------------------------------------
// sladm_ctrl: sequencer of the mixer
// Steps one request through squaring, goal, slew, gain, mix and trim.
// ----------------------------------------------------------------------------
module sladm_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  out_free_i,
  output sladm_pkg::sladm_ctl_t ctl_o
);
  import sladm_pkg::*;

  sladm_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_F_SQ;
      ST_F_SQ:   state_d = ST_F_DIV;
      ST_F_DIV:  state_d = ST_F_GOAL;
      ST_F_GOAL: state_d = ST_F_SLEW;
      ST_F_SLEW: state_d = ST_T_SQ;
      ST_T_SQ:   state_d = ST_T_DIV;
      ST_T_DIV:  state_d = ST_T_GOAL;
      ST_T_GOAL: state_d = ST_T_SLEW;
      ST_T_SLEW: state_d = ST_GAIN;
      ST_GAIN:   state_d = ST_MIX;
      ST_MIX:    state_d = ST_TRIM;
      ST_TRIM:   state_d = ST_DONE;
      ST_DONE:   if (out_free_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl_o = '0;
    unique case (state_q)
      ST_IDLE: ctl_o.idle = 1'b1;
      ST_F_SQ, ST_T_SQ: begin
        ctl_o.mul_en  = 1'b1;
        ctl_o.mul_sel = MUL_SQUARE;
      end
      ST_F_DIV, ST_T_DIV: begin
        ctl_o.mul_en  = 1'b1;
        ctl_o.mul_sel = MUL_RECIP;
        ctl_o.ld_mm   = 1'b1;
      end
      ST_F_GOAL, ST_T_GOAL: ctl_o.ld_goal = 1'b1;
      ST_F_SLEW, ST_T_SLEW: ctl_o.ld_level = 1'b1;
      ST_GAIN: begin
        ctl_o.mul_en  = 1'b1;
        ctl_o.mul_sel = MUL_GAIN;
      end
      ST_MIX: ctl_o.ld_mix = 1'b1;
      ST_TRIM: begin
        ctl_o.mul_en  = 1'b1;
        ctl_o.mul_sel = MUL_TRIM;
      end
      ST_DONE: ctl_o.ld_out = out_free_i;
      default: ctl_o = '0;
    endcase
    ctl_o.chan = (state_q == ST_T_SQ) || (state_q == ST_T_DIV) ||
                 (state_q == ST_T_GOAL) || (state_q == ST_T_SLEW);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: src/slew_limited_arcade_drive_mixer_core.sv
// ----------------------------------------------------------------------------
// slew_limited_arcade_drive_mixer_core: arcade drive mixer with slew limit
// Squared stick response, per-request slew limiting of the forward and turn
// levels, forward/turn mixing with a turn gain, and a trim on the right side.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                  Payload
//   -------   ---------  -------------------------  -----------------------------
//   in        in         in_valid_i / in_stall_o    fwd_stick, alt_turn_stick,
//                                                   turn_stick (8 bit signed)
//   out       out        out_valid_o / out_stall_i  left_drive, right_drive
//                                                   (8 bit signed)
//   config    in         APB psel/penable/pwrite    six registers at 4*index
//
// A request runs through 12 sequencer steps after the idle state that takes it;
// no new one is taken before idle returns. The single shared multiplier is used
// six times per request (two squares, two reciprocal multiplies, gain, trim), and
// each goal and slew update has a sequencer step of its own behind it.
// Reset clears the sequencer, the output valid flag and both stored levels and
// loads the register defaults; no clearing pass is needed.
// A new request is taken while a finished result still waits on out_stall_i;
// the sequencer only holds in its last step when the output register is full.
//
module slew_limited_arcade_drive_mixer_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [7:0]           fwd_stick_i,
  input  logic signed [7:0]           alt_turn_stick_i,
  input  logic signed [7:0]           turn_stick_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [7:0]           left_drive_o,
  output logic signed [7:0]           right_drive_o,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sladm_pkg::AddrW-1:0] paddr,
  input  logic [sladm_pkg::DataW-1:0] pwdata,
  output logic [sladm_pkg::DataW-1:0] prdata,
  output logic                        pready
);
  import sladm_pkg::*;

  sladm_cfg_t cfg;
  sladm_ctl_t ctl;

  logic             in_accept;
  logic             out_free;
  logic [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic [MulPW-1:0] mul_p;

  // Registers of the request in flight.
  logic [7:0]        fmag_q, tmag_q;
  logic              fneg_q, fnz_q, tneg_q, tnz_q;
  logic [14:0]       mm_q;
  logic [LevelW-1:0] goal_q, goal_d;
  logic [LevelW-1:0] fwd_level_q, fwd_level_d, turn_level_q, turn_level_d;
  logic [7:0]        left_res_q;
  logic [23:0]       rmag_q;
  logic              rneg_q;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        left_drive_q, right_drive_q;

  sladm_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  sladm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .out_free_i(out_free),
    .ctl_o     (ctl)
  );

  sladm_mul u_mul (
    .clk_i(clk_i),
    .en_i (ctl.mul_en),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (mul_p)
  );

  assign in_stall_o = ~ctl.idle;
  assign in_accept  = in_valid_i & ctl.idle;
  assign out_free   = ~out_valid_q | ~out_stall_i;

  // ---------------------------------------------------------------------------
  // Intake: stick magnitudes and signs. A strictly larger left X stick takes
  // the place of the turn stick when merging is on; a tie keeps the turn stick.
  // ---------------------------------------------------------------------------
  logic [7:0]        fwd_abs, alt_abs, turn_abs, tsel_abs;
  logic signed [7:0] tsel;

  always_comb begin
    fwd_abs  = fwd_stick_i[7]      ? 8'(-fwd_stick_i)      : fwd_stick_i;
    alt_abs  = alt_turn_stick_i[7] ? 8'(-alt_turn_stick_i) : alt_turn_stick_i;
    turn_abs = turn_stick_i[7]     ? 8'(-turn_stick_i)     : turn_stick_i;
    if (cfg.merge_turn_stick && (turn_abs < alt_abs)) begin
      tsel     = alt_turn_stick_i;
      tsel_abs = alt_abs;
    end else begin
      tsel     = turn_stick_i;
      tsel_abs = turn_abs;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      fmag_q <= fwd_abs;
      fneg_q <= fwd_stick_i[7];
      fnz_q  <= (fwd_stick_i != 8'sd0);
      tmag_q <= tsel_abs;
      tneg_q <= tsel[7];
      tnz_q  <= (tsel != 8'sd0);
    end
  end

  // ---------------------------------------------------------------------------
  // Multiplier operands. The square comes back as m*m; the goal divide by 127
  // is a multiply by the reciprocal on m*m*256.
  // ---------------------------------------------------------------------------
  logic [7:0]        mag_sel;
  logic [LevelW-1:0] lvl_cur;

  assign mag_sel = ctl.chan ? tmag_q : fmag_q;
  assign lvl_cur = ctl.chan ? turn_level_q : fwd_level_q;

  always_comb begin
    unique case (ctl.mul_sel)
      MUL_SQUARE: begin
        mul_a = MulAW'(mag_sel);
        mul_b = MulBW'(mag_sel);
      end
      MUL_RECIP: begin
        mul_a = MulAW'({mul_p[14:0], 8'b0});
        mul_b = GoalRecip;
      end
      MUL_GAIN: begin
        mul_a = MulAW'(turn_level_q);
        mul_b = MulBW'(cfg.turn_gain);
      end
      MUL_TRIM: begin
        mul_a = {1'b0, rmag_q};
        mul_b = MulBW'(cfg.right_trim);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl.ld_mm) begin
      mm_q <= mul_p[14:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Goal: the reciprocal quotient is at most one low, so one remainder check
  // against 127 fixes it. The result saturates at the top level value.
  // ---------------------------------------------------------------------------
  logic [15:0] q0;
  logic [23:0] x_w, q127, rem;
  logic [16:0] q_full;

  always_comb begin
    q0     = mul_p[RecipShift +: 16];
    x_w    = {1'b0, mm_q, 8'b0};
    q127   = {1'b0, q0, 7'b0} - {8'b0, q0};
    rem    = x_w - q127;
    q_full = {1'b0, q0} + {16'b0, (rem >= 24'd127)};
    goal_d = (q_full > {2'b00, LevelMax}) ? LevelMax : q_full[14:0];
  end

  always_ff @(posedge clk_i) begin
    if (ctl.ld_goal) begin
      goal_q <= goal_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Slew: move the level by the error when it is inside the step window,
  // otherwise by the rise or fall step, then clamp to the level range.
  // ---------------------------------------------------------------------------
  logic signed [16:0] err, rise_s, fall_s, step;
  logic signed [17:0] lvl_sum;
  logic [LevelW-1:0]  lvl_new;

  always_comb begin
    err    = $signed({2'b00, goal_q}) - $signed({2'b00, lvl_cur});
    rise_s = $signed({2'b00, cfg.rise_step});
    fall_s = $signed({cfg.fall_step[15], cfg.fall_step});
    if (((err > 0) && (err < rise_s)) || ((err <= 0) && (err > fall_s))) begin
      step = err;
    end else if (err > 0) begin
      step = rise_s;
    end else if (err < 0) begin
      step = fall_s;
    end else begin
      step = '0;
    end
    lvl_sum = $signed({3'b000, lvl_cur}) + $signed({step[16], step});
    if (lvl_sum < 0) begin
      lvl_new = '0;
    end else if (lvl_sum > $signed({3'b000, LevelMax})) begin
      lvl_new = LevelMax;
    end else begin
      lvl_new = lvl_sum[14:0];
    end
  end

  always_comb begin
    fwd_level_d  = fwd_level_q;
    turn_level_d = turn_level_q;
    if (ctl.ld_level) begin
      if (ctl.chan) begin
        turn_level_d = lvl_new;
      end else begin
        fwd_level_d = lvl_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_level_q  <= '0;
      turn_level_q <= '0;
    end else begin
      fwd_level_q  <= fwd_level_d;
      turn_level_q <= turn_level_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Mix: both terms are Q8.16. The left side is done here (divide by 2^16
  // toward zero); the right side magnitude goes on to the trim multiply.
  // ---------------------------------------------------------------------------
  logic [22:0]        f_mag, t_mag;
  logic signed [24:0] f_s, t_s, mix_sum, mix_dif, left_s, right_s;
  logic [24:0]        left_abs, right_abs;

  always_comb begin
    f_mag = {fwd_level_q, 8'b0};
    t_mag = mul_p[22:0];
    if (!fnz_q) begin
      f_s = '0;
    end else if (fneg_q) begin
      f_s = -$signed({2'b00, f_mag});
    end else begin
      f_s = $signed({2'b00, f_mag});
    end
    if (!tnz_q) begin
      t_s = '0;
    end else if (tneg_q) begin
      t_s = -$signed({2'b00, t_mag});
    end else begin
      t_s = $signed({2'b00, t_mag});
    end
    mix_sum   = f_s + t_s;
    mix_dif   = f_s - t_s;
    left_s    = cfg.standard_mix ? mix_sum : mix_dif;
    right_s   = cfg.standard_mix ? mix_dif : mix_sum;
    left_abs  = left_s[24]  ? 25'(-left_s)  : 25'(left_s);
    right_abs = right_s[24] ? 25'(-right_s) : 25'(right_s);
  end

  always_ff @(posedge clk_i) begin
    if (ctl.ld_mix) begin
      left_res_q <= sat_drive(left_s[24], {4'b0, left_abs[23:16]});
      rmag_q     <= right_abs[23:0];
      rneg_q     <= right_s[24];
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: the trimmed right magnitude is taken down by 2^31.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (ctl.ld_out) begin
      left_drive_q  <= left_res_q;
      right_drive_q <= sat_drive(rneg_q, mul_p[42:31]);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl.ld_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign left_drive_o  = left_drive_q;
  assign right_drive_o = right_drive_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o
  ) else $error("request taken but sequencer not busy");

  a_no_overwrite: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    ctl.ld_out |-> (!out_valid_q || !out_stall_i)
  ) else $error("result loaded over a stalled result");

  a_valid_from_seq: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(ctl.ld_out)
  ) else $error("result valid without a sequencer load");

endmodule

FILE: tb/sv/drive_mix_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// drive_mix_checker: prediction and comparison for the arcade drive mixer
// Follows register writes on the configuration bus, predicts the left and
// right drive of every accepted request and compares them with the results.
// ----------------------------------------------------------------------------
module drive_mix_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_valid_i,
  input  logic                        req_stall_i,
  input  logic signed [7:0]           fwd_stick_i,
  input  logic signed [7:0]           alt_turn_stick_i,
  input  logic signed [7:0]           turn_stick_i,
  input  logic                        res_valid_i,
  input  logic                        res_stall_i,
  input  logic signed [7:0]           left_drive_i,
  input  logic signed [7:0]           right_drive_i,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic                        pready_i,
  input  logic [sladm_pkg::AddrW-1:0] paddr_i,
  input  logic [sladm_pkg::DataW-1:0] pwdata_i,
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          requests_o,
  output int                          checked_o
);
  import sladm_pkg::*;

  typedef struct packed {
    logic signed [7:0] left;
    logic signed [7:0] right;
  } drive_pair_t;

  drive_pair_t pending_drives[$];

  // Shadow copy of the register file and of the two slewed levels.
  logic merge_on;
  logic std_mix;
  int   rise_q;
  int   fall_q;
  int   gain_q;
  int   trim_q;
  int   fwd_level;
  int   turn_level;

  function automatic int magnitude(input int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int sign_of(input int v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  // Squared response: |v|^2 * 256 / 127 in Q8.8, capped at the level range.
  function automatic int goal_from(input int v);
    int g;
    g = (magnitude(v) * magnitude(v) * 256) / 127;
    return (g > 32767) ? 32767 : g;
  endfunction

  function automatic int slew_level(input int level, input int goal);
    int err;
    int step;
    int nxt;
    err = goal - level;
    if ((err > 0 && err < rise_q) || (err <= 0 && err > fall_q)) step = err;
    else if (goal > level) step = rise_q;
    else if (goal < level) step = fall_q;
    else step = 0;
    nxt = level + step;
    if (nxt < 0) nxt = 0;
    if (nxt > 32767) nxt = 32767;
    return nxt;
  endfunction

  function automatic logic signed [7:0] clip_drive(input longint v);
    if (v > 127) v = 127;
    if (v < -127) v = -127;
    return 8'(v);
  endfunction

  function automatic drive_pair_t predict_drives(input int fwd, input int alt, input int turn);
    drive_pair_t res;
    longint f;
    longint t;
    longint lsum;
    longint rsum;
    if (merge_on && magnitude(turn) < magnitude(alt)) turn = alt;
    fwd_level  = slew_level(fwd_level, goal_from(fwd));
    turn_level = slew_level(turn_level, goal_from(turn));
    f = longint'(fwd_level) * 256 * sign_of(fwd);
    t = longint'(gain_q) * turn_level * sign_of(turn);
    lsum = std_mix ? f + t : f - t;
    rsum = std_mix ? f - t : f + t;
    res.left  = clip_drive(lsum / 65536);
    res.right = clip_drive((rsum * trim_q) / (longint'(1) << 31));
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    drive_pair_t want;
    if (!rst_ni) begin
      merge_on     = MergeRst;
      std_mix      = StdRst;
      rise_q       = int'(RiseRst);
      fall_q       = int'(signed'(FallRst));
      gain_q       = int'(GainRst);
      trim_q       = int'(TrimRst);
      fwd_level    = 0;
      turn_level   = 0;
      fail_count_o = 0;
      requests_o   = 0;
      checked_o    = 0;
      pending_drives.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[4:2])
          REG_MERGE:   merge_on = pwdata_i[0];
          REG_STD_MIX: std_mix  = pwdata_i[0];
          REG_RISE:    rise_q   = int'(pwdata_i[14:0]);
          REG_FALL:    fall_q   = int'(signed'(pwdata_i[15:0]));
          REG_GAIN:    gain_q   = int'(pwdata_i[7:0]);
          REG_TRIM:    trim_q   = int'(pwdata_i[15:0]);
          default: ;
        endcase
      end
      if (req_valid_i && !req_stall_i) begin
        pending_drives.push_back(predict_drives(int'(fwd_stick_i), int'(alt_turn_stick_i),
                                                int'(turn_stick_i)));
        requests_o++;
      end
      if (res_valid_i && !res_stall_i) begin
        if (pending_drives.size() == 0) begin
          $error("result with no request outstanding: left %0d, right %0d",
                 left_drive_i, right_drive_i);
          fail_count_o++;
        end else begin
          want = pending_drives.pop_front();
          checked_o++;
          if (left_drive_i !== want.left) begin
            $error("left_drive: expected %0d, got %0d", want.left, left_drive_i);
            fail_count_o++;
          end
          if (right_drive_i !== want.right) begin
            $error("right_drive: expected %0d, got %0d", want.right, right_drive_i);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = pending_drives.size();
  end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: top level for the slew-limited arcade drive mixer
// Drives stick requests and register settings into the mixer, applies random
// idling and a long output hold-off, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;
  import sladm_pkg::*;

  // Run shape. Phase 0 runs at the reset settings and opens with the directed
  // requests; every later phase first rewrites the whole register file.
  localparam int NumPhases     = 7;
  localparam int RandomPerPhase = 215;
  localparam int NumDirected   = 20;
  localparam int PressurePhase = 5;
  localparam int HoldOffCycles = 400;
  // Long enough for a request to run through the mixer, with margin on top.
  localparam int DrainCycles   = 20;
  localparam int SettleCycles  = 30;
  localparam int CycleLimit    = 400000;

  // The two spare register slots that the address decode must ignore.
  localparam logic [2:0] RegSpareLo = 3'd6;
  localparam logic [2:0] RegSpareHi = 3'd7;

  typedef enum int {
    IDLE_SINK_HEAVY,    // sender idles 11 percent, receiver 78 percent
    IDLE_SOURCE_HEAVY,  // the other way round
    IDLE_NONE
  } idle_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic signed [7:0] fwd_stick = '0;
  logic signed [7:0] alt_turn_stick = '0;
  logic signed [7:0] turn_stick = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic signed [7:0] left_drive;
  logic signed [7:0] right_drive;

  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  int fail_count;
  int pending;
  int requests;
  int checked;

  // Shared between the request process and the receiver process. Only the
  // request process writes them.
  idle_mode_e idle_mode = IDLE_SINK_HEAVY;
  int         phase = 0;

  // Directed requests as {fwd, alt_turn, turn}. They cover full deflection in
  // both directions, the -128 reading whose goal saturates, a larger left X
  // taking over the turn, equal magnitudes where the turn stick must win,
  // and returns to center.
  int directed_sticks [NumDirected][3] = '{
    '{0, 0, 0},       '{127, 0, 0},      '{127, 0, 0},      '{-127, 0, 0},
    '{-128, 0, 0},    '{-128, 0, 0},     '{0, 0, 127},      '{0, 0, -128},
    '{0, -127, 50},   '{0, 50, -50},     '{0, -50, 50},     '{127, 127, 127},
    '{-128, -128, -128}, '{-128, 127, -127}, '{1, -1, 1},   '{127, -128, 0},
    '{-1, 0, -1},     '{64, -100, 30},   '{0, 0, 0},        '{0, 0, 0}
  };

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  slew_limited_arcade_drive_mixer_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .fwd_stick_i     (fwd_stick),
    .alt_turn_stick_i(alt_turn_stick),
    .turn_stick_i    (turn_stick),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .left_drive_o    (left_drive),
    .right_drive_o   (right_drive),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  drive_mix_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_valid_i     (in_valid),
    .req_stall_i     (in_stall),
    .fwd_stick_i     (fwd_stick),
    .alt_turn_stick_i(alt_turn_stick),
    .turn_stick_i    (turn_stick),
    .res_valid_i     (out_valid),
    .res_stall_i     (out_stall),
    .left_drive_i    (left_drive),
    .right_drive_i   (right_drive),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .pready_i        (pready),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .requests_o      (requests),
    .checked_o       (checked)
  );

  // One register write: setup cycle, then access cycle until pready.
  task automatic reg_write(input logic [2:0] idx, input int value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_setting(input int merge, input int std, input int rise,
                               input int fall, input int gain, input int trim);
    reg_write(REG_MERGE, merge);
    reg_write(REG_STD_MIX, std);
    reg_write(REG_RISE, rise);
    reg_write(REG_FALL, fall);
    reg_write(REG_GAIN, gain);
    reg_write(REG_TRIM, trim);
  endtask

  // Offers one request after a random gap and holds it until it is taken.
  // Each falling edge carries at most one assignment to the valid.
  task automatic offer_request(input logic signed [7:0] fwd, input logic signed [7:0] alt,
                               input logic signed [7:0] turn);
    int gap_pct;
    gap_pct = (idle_mode == IDLE_SOURCE_HEAVY) ? 78 : (idle_mode == IDLE_SINK_HEAVY) ? 11 : 0;
    while ($urandom_range(99) < gap_pct) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
    end
    @(negedge clk_i);
    in_valid       <= 1'b1;
    fwd_stick      <= fwd;
    alt_turn_stick <= alt;
    turn_stick     <= turn;
    do @(posedge clk_i); while (in_stall);
  endtask

  // Receiver: random stalls by idle mode, plus one long hold-off at the start
  // of the pressure phase. The sender keeps offering during the hold-off, so
  // the mixer fills its output register and then stalls its input.
  initial begin : receiver
    int  hold_left;
    bit  hold_done;
    int  stall_pct;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (phase == PressurePhase && !hold_done) begin
        hold_left = HoldOffCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        stall_pct = (idle_mode == IDLE_SINK_HEAVY) ? 78 :
                    (idle_mode == IDLE_SOURCE_HEAVY) ? 11 : 0;
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Runaway guard: the slowest correct run is far below this.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int p;
    int n;
    int pick;
    logic signed [7:0] f;
    logic signed [7:0] a;
    logic signed [7:0] t;
    f = '0;
    a = '0;
    t = '0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (p = 0; p < NumPhases; p++) begin
      idle_mode = (p < 3) ? IDLE_SINK_HEAVY : (p < 5) ? IDLE_SOURCE_HEAVY : IDLE_NONE;

      // Registers change only with the mixer empty: every request has
      // returned its result and the sequencer has had time to settle.
      if (p > 0) begin
        while (pending != 0) @(posedge clk_i);
        repeat (DrainCycles) @(posedge clk_i);
        case (p)
          // Instant slewing at the widest steps, inverted mix, full trim.
          1: apply_setting(1, 0, 32767, -32768, 255, 32768);
          // Levels frozen, no turn weight, right side forced to zero.
          2: apply_setting(0, 1, 0, 0, 0, 0);
          // Crawling levels; the spare slots must not disturb anything.
          3: begin
            apply_setting(1, 1, 1, -1, 128, 16384);
            reg_write(RegSpareLo, $urandom);
            reg_write(RegSpareHi, $urandom);
          end
          // Positive fall step lets a level climb while moving down; the
          // trim above unity pushes the right side into saturation.
          4: apply_setting(0, 0, 300, 500, 200, 65535);
          5: apply_setting(1, 0, 4000, -6000, 179, 32605);
          default: apply_setting(1, 1, 12800, -12800, 179, 32605);
        endcase
      end
      phase = p;

      if (p == 0) begin
        for (n = 0; n < NumDirected; n++) begin
          offer_request(8'(directed_sticks[n][0]), 8'(directed_sticks[n][1]),
                        8'(directed_sticks[n][2]));
        end
      end

      // Mostly free random sticks. Some requests hold the previous sticks so
      // the levels settle on their goals, some tie the two turn magnitudes,
      // and some use only the extreme readings.
      for (n = 0; n < RandomPerPhase; n++) begin
        pick = $urandom_range(7);
        case (pick)
          0: ;
          1: begin
            f = 8'($urandom);
            t = 8'($urandom);
            a = $urandom_range(1) ? t : -t;
          end
          2: begin
            f = $urandom_range(1) ? ($urandom_range(1) ? 8'sd127 : -8'sd127) : -8'sd128;
            a = $urandom_range(1) ? -8'sd128 : 8'sd0;
            t = $urandom_range(1) ? 8'sd127 : -8'sd128;
          end
          default: begin
            f = 8'($urandom);
            a = 8'($urandom);
            t = 8'($urandom);
          end
        endcase
        offer_request(f, a, t);
      end

      @(negedge clk_i);
      in_valid <= 1'b0;
    end

    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("Summary: %0d stick requests under %0d register settings, %0d drive pairs compared.",
             requests, NumPhases, checked);
    $display("Summary: both mix modes, turn merging on and off, and a %0d-cycle output hold-off.",
             HoldOffCycles);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/sladm_pkg.sv
src/sladm_cfg.sv
src/sladm_mul.sv
src/sladm_ctrl.sv
src/slew_limited_arcade_drive_mixer_core.sv
tb/sv/drive_mix_checker.sv
tb/sv/testbench.sv
